// ----- rtl/waypoint_follower_step_macros.svh -----
// assertion macros for the waypoint follower
`ifndef WAYPOINT_FOLLOWER_STEP_MACROS_SVH
`define WAYPOINT_FOLLOWER_STEP_MACROS_SVH

// same-cycle implication
`define WPF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wpf assertion failed");

// next-cycle implication
`define WPF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wpf assertion failed");

`endif

// ----- rtl/wpf_pkg.sv -----
// shared types and constants of the waypoint follower
package wpf_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	localparam int CW   = 32;
	localparam int DW   = CW + 1;
	localparam int SW   = 2 * DW;
	localparam int RW   = DW + 1;
	localparam int PRW  = 20;
	localparam int PW   = PRW + DW;
	localparam int DSW  = DW + PRW - 1;

	localparam int SQ_STEPS   = DW;
	localparam int SQRT_STEPS = DW;
	localparam int DIV_STEPS  = PRW;
	localparam int ITW = 6;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_SET  = 2'd2;

	localparam logic [2:0] ST_MOVED    = 3'd0;
	localparam logic [2:0] ST_ADVANCED = 3'd1;
	localparam logic [2:0] ST_STOPPED  = 3'd2;
	localparam logic [2:0] ST_NO_PTS   = 3'd3;
	localparam logic [2:0] ST_FEW_PTS  = 3'd4;
	localparam logic [2:0] ST_LOADED   = 3'd5;
	localparam logic [2:0] ST_FULL     = 3'd6;

	localparam logic [1:0] REG_SPEED_X   = 2'd0;
	localparam logic [1:0] REG_SPEED_Y   = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	typedef struct packed {
		logic [1:0]        operation;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [2:0]         status;
	} out_item_t;

	typedef struct packed {
		logic [PRW-1:0] speed_x;
		logic [PRW-1:0] speed_y;
		logic [PRW-1:0] threshold;
	} cfg_t;

	typedef struct packed {
		logic q_write;
		logic q_read;
		logic pos_from_q;
		logic tgt_from_q;
		logic tgt_from_in;
		logic set_moving;
		logic clr_moving;
		logic set_started;
		logic sq_init;
		logic sq_step;
		logic sqrt_init;
		logic sqrt_step;
		logic div_init;
		logic div_step;
		logic pos_update;
	} cmd_t;

	typedef struct packed {
		logic q_full;
		logic q_empty;
		logic q_one;
		logic moving;
		logic started;
		logic arrived;
	} stat_t;

endpackage

// ----- rtl/wpf_ram.sv -----
// generic single-write, registered-read RAM
module wpf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/wpf_dp.sv -----
// datapath: position, target, waypoint queue, distance, root and step units
module wpf_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  wpf_pkg::cmd_t    cmd,
	input  wpf_pkg::in_item_t in_item,
	input  wpf_pkg::cfg_t    cfg,
	output wpf_pkg::stat_t   stat,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y
);
	import wpf_pkg::*;

	logic signed [CW-1:0] px_q, py_q, tx_q, ty_q;
	logic [QAW-1:0] head_q, tail_q;
	logic [QCW-1:0] count_q;
	logic moving_q, started_q;

	logic [2*CW-1:0] rdata;
	logic signed [CW-1:0] qx, qy;

	logic [DW-1:0] ax_q, ay_q, mx_q, my_q;
	logic sx_q, sy_q;
	logic [SW-1:0] cx_q, cy_q, s_q;
	logic [SW-1:0] sreg_q;
	logic [RW-1:0] rem_q;
	logic [DW-1:0] root_q;
	logic [PW-1:0] nx_q, ny_q;
	logic [DSW-1:0] dsh_q;
	logic [PRW-1:0] qtx_q, qty_q;

	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0] adx, ady;
	logic [2*PRW-1:0] thr2;
	logic [RW+1:0] rem_sh, trial;
	logic sq_ge, gex, gey;
	logic signed [CW+1:0] nposx, nposy;

	function automatic logic [QAW-1:0] wrap_inc(input logic [QAW-1:0] p);
		logic [QAW-1:0] r;
		r = (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
		logic signed [CW-1:0] r;
		if (v > (CW+2)'(2147483647)) begin
			r = 32'sh7fffffff;
		end else if (v < -(CW+2)'(64'sd2147483648)) begin
			r = 32'sh80000000;
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	wpf_ram #(.WIDTH(2 * CW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk   (clk),
		.we    (cmd.q_write),
		.waddr (tail_q),
		.wdata ({in_item.point_x, in_item.point_y}),
		.re    (cmd.q_read),
		.raddr (head_q),
		.rdata (rdata)
	);

	assign qx = rdata[2*CW-1:CW];
	assign qy = rdata[CW-1:0];

	assign dx  = {tx_q[CW-1], tx_q} - {px_q[CW-1], px_q};
	assign dy  = {ty_q[CW-1], ty_q} - {py_q[CW-1], py_q};
	assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign thr2 = (2*PRW)'(cfg.threshold) * (2*PRW)'(cfg.threshold);

	assign rem_sh = {rem_q, sreg_q[SW-1:SW-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign sq_ge  = rem_sh >= trial;
	assign gex    = nx_q >= {1'b0, dsh_q};
	assign gey    = ny_q >= {1'b0, dsh_q};

	assign nposx = sx_q ? {{2{px_q[CW-1]}}, px_q} - (CW+2)'(qtx_q)
	                    : {{2{px_q[CW-1]}}, px_q} + (CW+2)'(qtx_q);
	assign nposy = sy_q ? {{2{py_q[CW-1]}}, py_q} - (CW+2)'(qty_q)
	                    : {{2{py_q[CW-1]}}, py_q} + (CW+2)'(qty_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q      <= '0;
			py_q      <= '0;
			tx_q      <= '0;
			ty_q      <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			moving_q  <= 1'b1;
			started_q <= 1'b0;
		end else begin
			if (cmd.q_write) begin
				tail_q  <= wrap_inc(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.q_read) begin
				head_q  <= wrap_inc(head_q);
				count_q <= count_q - 1'b1;
			end
			if (cmd.pos_from_q) begin
				px_q <= qx;
				py_q <= qy;
			end
			if (cmd.tgt_from_q) begin
				tx_q <= qx;
				ty_q <= qy;
			end
			if (cmd.tgt_from_in) begin
				tx_q <= in_item.point_x;
				ty_q <= in_item.point_y;
			end
			if (cmd.set_moving) begin
				moving_q <= 1'b1;
			end
			if (cmd.clr_moving) begin
				moving_q <= 1'b0;
			end
			if (cmd.set_started) begin
				started_q <= 1'b1;
			end
			if (cmd.pos_update) begin
				px_q <= sat(nposx);
				py_q <= sat(nposy);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_init) begin
			ax_q <= adx;
			ay_q <= ady;
			mx_q <= adx;
			my_q <= ady;
			sx_q <= dx[DW-1];
			sy_q <= dy[DW-1];
			cx_q <= SW'(adx);
			cy_q <= SW'(ady);
			s_q  <= '0;
		end
		if (cmd.sq_step) begin
			s_q  <= s_q + (mx_q[0] ? cx_q : '0) + (my_q[0] ? cy_q : '0);
			cx_q <= cx_q << 1;
			cy_q <= cy_q << 1;
			mx_q <= mx_q >> 1;
			my_q <= my_q >> 1;
		end
		if (cmd.sqrt_init) begin
			sreg_q <= s_q;
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			sreg_q <= sreg_q << 2;
			rem_q  <= sq_ge ? RW'(rem_sh - trial) : RW'(rem_sh);
			root_q <= {root_q[DW-2:0], sq_ge};
		end
		if (cmd.div_init) begin
			nx_q  <= PW'(cfg.speed_x) * PW'(ax_q);
			ny_q  <= PW'(cfg.speed_y) * PW'(ay_q);
			dsh_q <= {root_q, (PRW-1)'(0)};
			qtx_q <= '0;
			qty_q <= '0;
		end
		if (cmd.div_step) begin
			nx_q  <= gex ? nx_q - PW'(dsh_q) : nx_q;
			ny_q  <= gey ? ny_q - PW'(dsh_q) : ny_q;
			dsh_q <= dsh_q >> 1;
			qtx_q <= {qtx_q[PRW-2:0], gex};
			qty_q <= {qty_q[PRW-2:0], gey};
		end
	end

	assign stat.q_full  = count_q == QCW'(QUEUE_DEPTH);
	assign stat.q_empty = count_q == '0;
	assign stat.q_one   = count_q == QCW'(1);
	assign stat.moving  = moving_q;
	assign stat.started = started_q;
	assign stat.arrived = s_q <= SW'(thr2);

	assign pos_x = px_q;
	assign pos_y = py_q;

endmodule

// ----- rtl/wpf_ctrl.sv -----
// controller: sequences each request through the datapath
module wpf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     operation,
	input  wpf_pkg::stat_t stat,
	input  logic           out_free,
	output logic           in_ready,
	output wpf_pkg::cmd_t  cmd,
	output logic           done,
	output logic [2:0]     status
);
	import wpf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_POP_POS, S_POP_TGT, S_SQ_INIT, S_SQ, S_CMP, S_ARR_TGT,
		S_SQRT, S_DIV_INIT, S_DIV, S_POS, S_DONE
	} state_t;

	state_t state_q;
	logic [ITW-1:0] it_q;
	logic [2:0] status_q;
	logic accept;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign done     = state_q == S_DONE && out_free;
	assign status   = status_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (operation)
						OP_LOAD: cmd.q_write = !stat.q_full;
						OP_SET: begin
							cmd.tgt_from_in = 1'b1;
							cmd.set_moving  = 1'b1;
						end
						OP_TICK: begin
							if (stat.moving && !stat.started && !stat.q_empty && !stat.q_one) begin
								cmd.q_read = 1'b1;
							end
							cmd.sq_init = stat.moving && stat.started;
						end
						default: cmd = '0;
					endcase
				end
			end
			S_POP_POS: begin
				cmd.pos_from_q = 1'b1;
				cmd.q_read     = 1'b1;
			end
			S_POP_TGT: begin
				cmd.tgt_from_q  = 1'b1;
				cmd.set_started = 1'b1;
			end
			S_SQ_INIT: cmd.sq_init = 1'b1;
			S_SQ:      cmd.sq_step = 1'b1;
			S_CMP: begin
				cmd.q_read     = stat.arrived && !stat.q_empty;
				cmd.clr_moving = stat.arrived && stat.q_empty;
				cmd.sqrt_init  = !stat.arrived;
			end
			S_ARR_TGT:  cmd.tgt_from_q = 1'b1;
			S_SQRT:     cmd.sqrt_step  = 1'b1;
			S_DIV_INIT: cmd.div_init   = 1'b1;
			S_DIV:      cmd.div_step   = 1'b1;
			S_POS:      cmd.pos_update = 1'b1;
			S_DONE:     cmd = '0;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			it_q     <= '0;
			status_q <= ST_MOVED;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						it_q <= '0;
						unique case (operation)
							OP_LOAD: begin
								state_q  <= S_DONE;
								status_q <= stat.q_full ? ST_FULL : ST_LOADED;
							end
							OP_SET: begin
								state_q  <= S_DONE;
								status_q <= ST_ADVANCED;
							end
							OP_TICK: begin
								priority if (!stat.moving) begin
									state_q  <= S_DONE;
									status_q <= ST_STOPPED;
								end else if (stat.started) begin
									state_q <= S_SQ;
								end else if (stat.q_empty) begin
									state_q  <= S_DONE;
									status_q <= ST_NO_PTS;
								end else if (stat.q_one) begin
									state_q  <= S_DONE;
									status_q <= ST_FEW_PTS;
								end else begin
									state_q <= S_POP_POS;
								end
							end
							default: begin
								state_q  <= S_DONE;
								status_q <= ST_STOPPED;
							end
						endcase
					end
				end
				S_POP_POS: state_q <= S_POP_TGT;
				S_POP_TGT: state_q <= S_SQ_INIT;
				S_SQ_INIT: begin
					state_q <= S_SQ;
					it_q    <= '0;
				end
				S_SQ: begin
					if (it_q == ITW'(SQ_STEPS - 1)) begin
						state_q <= S_CMP;
						it_q    <= '0;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				S_CMP: begin
					priority if (!stat.arrived) begin
						state_q <= S_SQRT;
					end else if (!stat.q_empty) begin
						state_q <= S_ARR_TGT;
					end else begin
						state_q  <= S_DONE;
						status_q <= ST_STOPPED;
					end
				end
				S_ARR_TGT: begin
					state_q  <= S_DONE;
					status_q <= ST_ADVANCED;
				end
				S_SQRT: begin
					if (it_q == ITW'(SQRT_STEPS - 1)) begin
						state_q <= S_DIV_INIT;
						it_q    <= '0;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				S_DIV_INIT: state_q <= S_DIV;
				S_DIV: begin
					if (it_q == ITW'(DIV_STEPS - 1)) begin
						state_q <= S_POS;
						it_q    <= '0;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				S_POS: begin
					state_q  <= S_DONE;
					status_q <= ST_MOVED;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/waypoint_follower_step.sv -----
// top level of the waypoint follower: config registers, output register, assertions
//
// in channel (in_valid/in_ready/in_data) takes one request: load waypoint,
// tick, or set target; out channel (out_valid/out_ready/out_data) returns
// exactly one result per request with the position and a status code.
// cfg channel writes speed_x (0), speed_y (1), arrive_threshold (2); it is
// always ready and other indexes are ignored; write only while idle.
// load, set target, stopped or start-up refusals go from accept straight
// to the hand-off; a tick that moves runs through accept, 33 shift-add
// square steps, one compare, 33 root digits, divide load and 20 divide
// steps for both axes, one update and one hand-off; start-up first pops
// position and target; an arrival pops the next target or stops.
// one request is worked at a time; the next is taken once the result sits
// in the output register, which holds it while the receiver stalls.
// a result that finds the output register still full waits for it.
// reset clears position, target, queue pointers and flags; moving is set
// and the registers return to 1024. queue entries are never cleared.
module waypoint_follower_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wpf_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output wpf_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [19:0]         cfg_data
);
	import wpf_pkg::*;

	`include "waypoint_follower_step_macros.svh"

	cfg_t cfg_q;
	cmd_t cmd;
	stat_t stat;
	logic done, out_free, out_valid_q;
	logic [2:0] status;
	logic signed [CW-1:0] pos_x, pos_y;
	out_item_t out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_x   <= PRW'(1024);
			cfg_q.speed_y   <= PRW'(1024);
			cfg_q.threshold <= PRW'(1024);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SPEED_X:   cfg_q.speed_x   <= cfg_data;
				REG_SPEED_Y:   cfg_q.speed_y   <= cfg_data;
				REG_THRESHOLD: cfg_q.threshold <= cfg_data;
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	wpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (in_data.operation),
		.stat      (stat),
		.out_free  (out_free),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.done      (done),
		.status    (status)
	);

	wpf_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_item (in_data),
		.cfg     (cfg_q),
		.stat    (stat),
		.pos_x   (pos_x),
		.pos_y   (pos_y)
	);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q.pos_x  <= pos_x;
			out_q.pos_y  <= pos_y;
			out_q.status <= status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`WPF_ASSERT_NXT(a_busy_after_request, in_valid && in_ready, !in_ready)
	`WPF_ASSERT_IMP(a_no_overwrite, done, !out_valid_q || out_ready)
	`WPF_ASSERT_IMP(a_queue_flags, stat.q_full, !stat.q_empty && !stat.q_one)

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench of the waypoint follower with a predicting scoreboard
`timescale 1ns / 100ps

import wpf_pkg::*;

class follower_scoreboard;
	logic [19:0] spd_x, spd_y, thr;
	longint pos_x, pos_y, tgt_x, tgt_y;
	logic [63:0] fifo [QUEUE_DEPTH];
	int head, tail, count;
	bit started, moving;
	out_item_t pending [$];
	int errors, checked;

	function new();
		spd_x = 20'd1024;
		spd_y = 20'd1024;
		thr = 20'd1024;
		pos_x = 0;
		pos_y = 0;
		tgt_x = 0;
		tgt_y = 0;
		head = 0;
		tail = 0;
		count = 0;
		started = 0;
		moving = 1;
		errors = 0;
		checked = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [19:0] val);
		if (idx == REG_SPEED_X) spd_x = val;
		else if (idx == REG_SPEED_Y) spd_y = val;
		else if (idx == REG_THRESHOLD) thr = val;
	endfunction

	function void pop(output longint x, output longint y);
		logic [63:0] e;
		e = fifo[head];
		x = longint'($signed(e[63:32]));
		y = longint'($signed(e[31:0]));
		head = (head + 1 >= QUEUE_DEPTH) ? 0 : head + 1;
		count--;
	endfunction

	function logic [33:0] isqrt(logic [65:0] s);
		logic [33:0] lo, hi, mid;
		logic [67:0] sq;
		lo = 0;
		hi = 34'd1 << 33;
		while (lo + 1 < hi) begin
			mid = lo + ((hi - lo) >> 1);
			sq = mid * mid;
			if (sq <= {2'b0, s}) lo = mid;
			else hi = mid;
		end
		return lo;
	endfunction

	function longint advance(longint p, longint d, logic [33:0] mag, logic [19:0] spd,
		logic [33:0] span);
		logic [53:0] stp;
		longint v;
		stp = (54'(spd) * 54'(mag)) / 54'(span);
		v = (d < 0) ? p - longint'(stp) : p + longint'(stp);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v;
	endfunction

	function logic [2:0] tick();
		longint dx, dy;
		logic [33:0] ax, ay, span;
		logic [65:0] s;
		logic [39:0] t2;
		if (!moving) return ST_STOPPED;
		if (!started) begin
			if (count == 0) return ST_NO_PTS;
			if (count == 1) return ST_FEW_PTS;
			pop(pos_x, pos_y);
			pop(tgt_x, tgt_y);
			started = 1;
		end
		dx = tgt_x - pos_x;
		dy = tgt_y - pos_y;
		ax = 34'((dx < 0) ? -dx : dx);
		ay = 34'((dy < 0) ? -dy : dy);
		s = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
		t2 = 40'(thr) * 40'(thr);
		if (s <= 66'(t2)) begin
			if (count > 0) begin
				pop(tgt_x, tgt_y);
				return ST_ADVANCED;
			end
			moving = 0;
			return ST_STOPPED;
		end
		span = isqrt(s);
		if (span == 0) span = 34'd1;
		pos_x = advance(pos_x, dx, ax, spd_x, span);
		pos_y = advance(pos_y, dy, ay, spd_y, span);
		return ST_MOVED;
	endfunction

	function void note_request(in_item_t r);
		out_item_t o;
		if (r.operation == OP_LOAD) begin
			if (count >= QUEUE_DEPTH) o.status = ST_FULL;
			else begin
				fifo[tail] = {r.point_x, r.point_y};
				tail = (tail + 1 >= QUEUE_DEPTH) ? 0 : tail + 1;
				count++;
				o.status = ST_LOADED;
			end
		end else if (r.operation == OP_TICK) o.status = tick();
		else if (r.operation == OP_SET) begin
			tgt_x = r.point_x;
			tgt_y = r.point_y;
			moving = 1;
			o.status = ST_ADVANCED;
		end else o.status = ST_STOPPED;
		o.pos_x = pos_x[31:0];
		o.pos_y = pos_y[31:0];
		pending = {pending, o};
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		checked++;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result %p", got);
			return;
		end
		want = pending.pop_front();
		if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
			got.status !== want.status) begin
			errors++;
			if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
		end
	endfunction
endclass

module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0, cfg_valid = 0, cfg_ready;
	in_item_t in_data = '0;
	out_item_t out_data;
	logic [1:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;
	follower_scoreboard sb = new();
	longint cycles = 0;
	bit hold_off = 0;
	int sent = 0;

	waypoint_follower_step dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd2000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(out_data);
		if (in_valid && in_ready) sb.note_request(in_data);
	end

	always @(posedge clk) begin
		if (hold_off) out_ready <= 0;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	initial begin
		forever begin
			wait (hold_off);
			repeat (1500) @(posedge clk);
			hold_off = 0;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	task automatic send(logic [1:0] op, logic [31:0] x, logic [31:0] y);
		int g;
		in_valid <= 1;
		in_data <= '{op, x, y};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [19:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] near(logic [31:0] base, int spread);
		return base + $urandom_range(0, 2 * spread) - spread;
	endfunction

	task automatic random_phase(int n);
		logic [31:0] bx, by;
		int kind;
		repeat (n) begin
			kind = $urandom_range(0, 99);
			bx = $urandom;
			by = $urandom;
			if (kind < 8) send(2'($urandom_range(0, 3)), $urandom, $urandom);
			else if (kind < 40) send(OP_LOAD, near(bx & 32'h0000ffff, 40000),
				near(by & 32'h0000ffff, 40000));
			else if (kind < 45) send(OP_SET, near(bx >> 12, 30000), $urandom);
			else send(OP_TICK, $urandom, $urandom);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(OP_TICK, 0, 0);
		send(OP_LOAD, 32'h7fffffff, 32'h80000000);
		send(OP_TICK, 0, 0);
		send(OP_LOAD, 32'h80000000, 32'h7fffffff);
		send(OP_TICK, 0, 0);
		send(OP_TICK, 0, 0);
		send(2'd3, 32'hffffffff, 32'hffffffff);
		send(OP_SET, 32'h7fffffff, 32'h7fffffff);
		send(OP_TICK, 0, 0);
		send(OP_SET, 32'h00000100, 32'hffffff00);
		send(OP_TICK, 0, 0);
		send(OP_TICK, 0, 0);
		send(OP_TICK, 0, 0);
		drain();
		write_reg(REG_SPEED_X, 20'hfffff);
		write_reg(REG_SPEED_Y, 20'd0);
		write_reg(REG_THRESHOLD, 20'hfffff);
		send(OP_SET, 32'h00200000, 32'h80000000);
		send(OP_TICK, 0, 0);
		send(OP_SET, 32'h00010000, 0);
		send(OP_TICK, 0, 0);
		send(OP_TICK, 0, 0);
		repeat (70) send(OP_LOAD, $urandom, $urandom);
		drain();
		write_reg(REG_THRESHOLD, 20'd0);
		write_reg(REG_SPEED_Y, 20'hfffff);
		random_phase(150);
		hold_off = 1;
		random_phase(80);
		drain();
		write_reg(REG_SPEED_X, 20'($urandom));
		write_reg(REG_SPEED_Y, 20'($urandom));
		write_reg(REG_THRESHOLD, 20'($urandom_range(0, 200000)));
		random_phase(200);
		drain();
		write_reg(REG_SPEED_X, 20'd1);
		write_reg(REG_SPEED_Y, 20'd1024);
		write_reg(REG_THRESHOLD, 20'd50000);
		random_phase(150);
		drain();
		$display("sent %0d requests, checked %0d results over several speed and",
			sent, sb.checked);
		$display("threshold settings, including queue overflow and a long output stall");
		if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
